// File: hw/rtl/evh_pkg.sv
package evh_pkg;

	localparam int MAX_FRAME_SAMPLES = 4096;
	localparam int SAMPLE_CAP = (MAX_FRAME_SAMPLES < 8191) ? MAX_FRAME_SAMPLES : 8191;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int PROD_W   = 2 * MAG_W;
	localparam int SQ_W     = 2 * SAMPLE_W - 1;
	localparam int SUM_W    = 43;
	localparam int CNT_W    = 13;
	localparam int CROSS_W  = 12;
	localparam int RUN_W    = 10;
	localparam int TOTAL_W  = 32;
	localparam int THR_W    = 16;
	localparam int THR_SQ_W = 2 * THR_W;
	localparam int LIM_W    = THR_SQ_W + CNT_W;
	localparam int IDX_W    = 2;
	localparam int DATA_W   = 16;

	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
	localparam logic [CROSS_W-1:0] CROSS_MAX = '1;
	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [CNT_W-1:0]   CNT_CAP   = CNT_W'(SAMPLE_CAP);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [IDX_W-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [IDX_W-1:0] REG_MIN_SPEECH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_MIN_SILENCE = 2'd2;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [RUN_W-1:0] min_speech;
		logic [RUN_W-1:0] min_silence;
	} evh_cfg_t;

	typedef struct packed {
		logic               is_clear;
		logic [SUM_W-1:0]   sum;
		logic [CNT_W-1:0]   count;
		logic [CROSS_W-1:0] crossings;
	} evh_entry_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_DECIDE
	} evh_bstate_t;

endpackage

// File: hw/rtl/evh_if.sv
interface evh_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic signed [evh_pkg::SAMPLE_W-1:0] sample;
	logic                          last_in_frame;

	modport source (output valid, action, sample, last_in_frame, input ready);
	modport sink (input valid, action, sample, last_in_frame, output ready);
endinterface

interface evh_out_if;
	logic                          valid;
	logic                          ready;
	logic                          speech_active;
	logic                          frame_energetic;
	logic [evh_pkg::SUM_W-1:0]     frame_sum_squares;
	logic [evh_pkg::CNT_W-1:0]     frame_samples;
	logic [evh_pkg::CROSS_W-1:0]   frame_zero_crossings;
	logic [evh_pkg::TOTAL_W-1:0]   frame_total;
	logic [evh_pkg::TOTAL_W-1:0]   speech_total;

	modport source (output valid, speech_active, frame_energetic, frame_sum_squares,
		frame_samples, frame_zero_crossings, frame_total, speech_total,
		input ready);
	modport sink (input valid, speech_active, frame_energetic, frame_sum_squares,
		frame_samples, frame_zero_crossings, frame_total, speech_total,
		output ready);
endinterface

interface evh_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [evh_pkg::IDX_W-1:0]   index;
	logic [evh_pkg::DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/energy_vad_hysteresis.sv
// Energy voice activity detector with hangover. Signed Q15 samples enter one per clock unless the
// front stalls; a frame ends on a sample marked last_in_frame, and that sample yields one result
// word with the hysteresis speech state, the raw energy decision, the frame's saturating sum of
// squares, sample and crossing counts, and running totals. A clear word resets frame, run and
// total state but not the configuration, and yields no result. The front squares and accumulates
// each sample at one word per cycle, stalling when a frame end or clear meets a full queue; frame
// records pass through a four-entry queue to the back, which forms threshold squared times sample
// count, then makes the compare and state update once the output is free; a clear is taken as it
// is popped. A run of short frames fills the queue and throttles input. Configuration writes are
// always accepted and should be made with the block idle; a new threshold is squared in a register.
module energy_vad_hysteresis (
	input  logic clk,
	input  logic arst_n,
	evh_in_if.sink    samples,
	evh_out_if.source results,
	evh_cfg_if.sink   cfg
);

	evh_pkg::evh_cfg_t   cfg_q;
	evh_pkg::evh_entry_t push_entry;
	evh_pkg::evh_entry_t pop_entry;
	logic                push;
	logic                pop;
	logic                full;
	logic                empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= '0;
			cfg_q.min_speech  <= evh_pkg::RUN_W'(1);
			cfg_q.min_silence <= evh_pkg::RUN_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				evh_pkg::REG_THRESHOLD:   cfg_q.threshold   <= cfg.data;
				evh_pkg::REG_MIN_SPEECH:  cfg_q.min_speech  <= cfg.data[evh_pkg::RUN_W-1:0];
				evh_pkg::REG_MIN_SILENCE: cfg_q.min_silence <= cfg.data[evh_pkg::RUN_W-1:0];
				default: ;
			endcase
		end
	end

	evh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	evh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (full),
		.empty      (empty)
	);

	evh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.results   (results)
	);

endmodule

// File: hw/rtl/evh_fifo.sv
module evh_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  evh_pkg::evh_entry_t push_entry,
	input  logic                pop,
	output evh_pkg::evh_entry_t pop_entry,
	output logic                full,
	output logic                empty
);

	evh_pkg::evh_entry_t mem [evh_pkg::FIFO_DEPTH];
	logic [evh_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [evh_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [evh_pkg::FIFO_AW:0]   count_q;

	assign full      = (count_q == (evh_pkg::FIFO_AW+1)'(evh_pkg::FIFO_DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Entry written into a full queue.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Entry taken from an empty queue.");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (evh_pkg::FIFO_AW+1)'(evh_pkg::FIFO_DEPTH))
		else $error("Queue fill count beyond its depth.");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("Queue fill count did not follow a write.");

endmodule

// File: hw/rtl/evh_front.sv
module evh_front (
	input  logic                clk,
	input  logic                arst_n,
	evh_in_if.sink              samples,
	output logic                push,
	output evh_pkg::evh_entry_t push_entry,
	input  logic                full
);

	logic                          valid_s1;
	logic                          clear_s1;
	logic                          neg_s1;
	logic                          last_s1;
	logic [evh_pkg::SQ_W-1:0]      sq_s1;

	logic [evh_pkg::CNT_W-1:0]     count_q;
	logic [evh_pkg::SUM_W-1:0]     sum_q;
	logic                          prev_neg_q;
	logic [evh_pkg::CROSS_W-1:0]   cross_q;

	logic                          adv;
	logic                          accept;
	logic                          in_neg;
	logic [evh_pkg::MAG_W-1:0]     in_mag;
	logic [evh_pkg::PROD_W-1:0]    in_prod;
	logic                          step_cross;
	logic [evh_pkg::CROSS_W-1:0]   cross_nx;
	logic [evh_pkg::SUM_W:0]       sum_wide;
	logic [evh_pkg::SUM_W-1:0]     sum_nx;
	logic [evh_pkg::CNT_W-1:0]     count_nx;

	assign adv           = valid_s1 && !((clear_s1 || last_s1) && full);
	assign samples.ready = !valid_s1 || adv;
	assign accept        = samples.valid && samples.ready;

	assign in_neg  = samples.sample[evh_pkg::SAMPLE_W-1];
	assign in_mag  = in_neg ? (evh_pkg::MAG_W'(1) << evh_pkg::SAMPLE_W) - {1'b0, samples.sample}
		: {1'b0, samples.sample};
	assign in_prod = in_mag * in_mag;

	assign step_cross = (count_q != '0) && (neg_s1 != prev_neg_q) && (cross_q != evh_pkg::CROSS_MAX);
	assign cross_nx   = cross_q + evh_pkg::CROSS_W'(step_cross);
	assign sum_wide   = {1'b0, sum_q} + (evh_pkg::SUM_W+1)'(sq_s1);
	assign sum_nx     = sum_wide[evh_pkg::SUM_W] ? evh_pkg::SUM_MAX : sum_wide[evh_pkg::SUM_W-1:0];
	assign count_nx   = (count_q < evh_pkg::CNT_CAP) ? count_q + 1'b1 : count_q;

	assign push                 = adv && (clear_s1 || last_s1);
	assign push_entry.is_clear  = clear_s1;
	assign push_entry.sum       = sum_nx;
	assign push_entry.count     = count_nx;
	assign push_entry.crossings = cross_nx;

	always_ff @(posedge clk) begin
		if (accept) begin
			clear_s1 <= samples.action;
			neg_s1   <= in_neg;
			last_s1  <= samples.last_in_frame;
			sq_s1    <= in_prod[evh_pkg::SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			count_q    <= '0;
			sum_q      <= '0;
			prev_neg_q <= 1'b0;
			cross_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				if (clear_s1 || last_s1) begin
					count_q    <= '0;
					sum_q      <= '0;
					prev_neg_q <= 1'b0;
					cross_q    <= '0;
				end else begin
					count_q    <= count_nx;
					sum_q      <= sum_nx;
					prev_neg_q <= neg_s1;
					cross_q    <= cross_nx;
				end
			end
		end
	end

endmodule

// File: hw/rtl/evh_back.sv
module evh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  evh_pkg::evh_cfg_t   cfg,
	input  logic                empty,
	input  evh_pkg::evh_entry_t pop_entry,
	output logic                pop,
	evh_out_if.source           results
);

	evh_pkg::evh_bstate_t          state_q;
	evh_pkg::evh_bstate_t          state_nx;
	evh_pkg::evh_entry_t           ent_q;
	logic [evh_pkg::THR_SQ_W-1:0]  thr_sq_q;
	logic [evh_pkg::LIM_W-1:0]     limit_q;
	logic [evh_pkg::RUN_W-1:0]     speech_run_q;
	logic [evh_pkg::RUN_W-1:0]     silence_run_q;
	logic                          speech_q;
	logic [evh_pkg::TOTAL_W-1:0]   frames_q;
	logic [evh_pkg::TOTAL_W-1:0]   speech_tot_q;
	logic                          out_valid_q;

	logic                          load;
	logic                          energetic;
	logic [evh_pkg::RUN_W-1:0]     speech_run_nx;
	logic [evh_pkg::RUN_W-1:0]     silence_run_nx;
	logic                          speech_nx;
	logic [evh_pkg::TOTAL_W-1:0]   frames_nx;
	logic [evh_pkg::TOTAL_W-1:0]   speech_tot_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			evh_pkg::B_IDLE: begin
				if (!empty && !pop_entry.is_clear) begin
					state_nx = evh_pkg::B_MUL;
				end
			end
			evh_pkg::B_MUL: begin
				state_nx = evh_pkg::B_DECIDE;
			end
			evh_pkg::B_DECIDE: begin
				if (!out_valid_q || results.ready) begin
					state_nx = evh_pkg::B_IDLE;
				end
			end
			default: state_nx = evh_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		unique case (state_q)
			evh_pkg::B_IDLE:   pop  = !empty;
			evh_pkg::B_MUL:    ;
			evh_pkg::B_DECIDE: load = !out_valid_q || results.ready;
			default:           ;
		endcase
	end

	always_comb begin
		energetic = evh_pkg::LIM_W'(ent_q.sum) > limit_q;
		if (energetic) begin
			speech_run_nx  = (speech_run_q != evh_pkg::RUN_MAX) ? speech_run_q + 1'b1 : speech_run_q;
			silence_run_nx = '0;
			speech_nx      = (speech_run_nx >= cfg.min_speech) ? 1'b1 : speech_q;
		end else begin
			silence_run_nx = (silence_run_q != evh_pkg::RUN_MAX) ? silence_run_q + 1'b1
				: silence_run_q;
			speech_run_nx  = '0;
			speech_nx      = (silence_run_nx >= cfg.min_silence) ? 1'b0 : speech_q;
		end
		frames_nx     = (frames_q != evh_pkg::TOTAL_MAX) ? frames_q + 1'b1 : frames_q;
		speech_tot_nx = (speech_nx && speech_tot_q != evh_pkg::TOTAL_MAX)
			? speech_tot_q + 1'b1 : speech_tot_q;
	end

	assign results.valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= pop_entry;
		end
		if (state_q == evh_pkg::B_MUL) begin
			limit_q <= thr_sq_q * ent_q.count;
		end
		if (load) begin
			results.speech_active        <= speech_nx;
			results.frame_energetic      <= energetic;
			results.frame_sum_squares    <= ent_q.sum;
			results.frame_samples        <= ent_q.count;
			results.frame_zero_crossings <= ent_q.crossings;
			results.frame_total          <= frames_nx;
			results.speech_total         <= speech_tot_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= evh_pkg::B_IDLE;
			thr_sq_q      <= '0;
			speech_run_q  <= '0;
			silence_run_q <= '0;
			speech_q      <= 1'b0;
			frames_q      <= '0;
			speech_tot_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_nx;
			thr_sq_q <= cfg.threshold * cfg.threshold;
			if (pop && pop_entry.is_clear) begin
				speech_run_q  <= '0;
				silence_run_q <= '0;
				speech_q      <= 1'b0;
				frames_q      <= '0;
				speech_tot_q  <= '0;
			end else if (load) begin
				speech_run_q  <= speech_run_nx;
				silence_run_q <= silence_run_nx;
				speech_q      <= speech_nx;
				frames_q      <= frames_nx;
				speech_tot_q  <= speech_tot_nx;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
